FILE: rtl/core/section_range_lookup_translate_unit_macros.svh
// ----------------------------------------------------------------------------
// section range lookup translate unit: assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SECTION_RANGE_LOOKUP_TRANSLATE_UNIT_MACROS_SVH
`define SECTION_RANGE_LOOKUP_TRANSLATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRLT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("srlt assertion failed");

// next-cycle implication
`define SRLT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("srlt assertion failed");

`else

`define SRLT_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define SRLT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/core/srlt_pkg.sv
// ----------------------------------------------------------------------------
// srlt_pkg
// shared constants, codes and structs of the section lookup unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srlt_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NUM_W        = $clog2(MAX_SECTIONS + 1);

    localparam int WORD_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int ENTRY_IDX_W  = 4;
    localparam int COUNT_W      = 5;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD      = 2'd0,
        ACT_FIND_VIRT = 2'd1,
        ACT_FIND_RAW  = 2'd2,
        ACT_TRANSLATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SKIP,
        OP_SEARCH,
        OP_TRANSLATE
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] virtual_base;
        logic [WORD_W-1:0] virtual_size;
        logic [WORD_W-1:0] raw_base;
        logic [WORD_W-1:0] raw_size;
    } entry_t;

    typedef struct packed {
        op_t               op;
        logic              use_raw;
        logic [IDX_W-1:0]  entry_index;
        entry_t            entry;
        logic [WORD_W-1:0] address;
        logic [WORD_W:0]   range_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic             walking;
        logic [IDX_W-1:0] walk_idx;
    } bk_stat_t;

endpackage

FILE: rtl/core/srlt_if.sv
// ----------------------------------------------------------------------------
// srlt interfaces
// item, result and configuration channels, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srlt_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  entry_index;
    logic [31:0] load_virtual_base;
    logic [31:0] load_virtual_size;
    logic [31:0] load_raw_base;
    logic [31:0] load_raw_size;
    logic [31:0] query_address;
    logic [31:0] query_length;

    modport source (
        output valid, action, entry_index, load_virtual_base, load_virtual_size,
               load_raw_base, load_raw_size, query_address, query_length,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, load_virtual_base, load_virtual_size,
               load_raw_base, load_raw_size, query_address, query_length,
        output ready
    );
endinterface

interface srlt_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [3:0]  section_index;
    logic [31:0] raw_address;

    modport source (output valid, found, section_index, raw_address, input ready);
    modport sink   (input valid, found, section_index, raw_address, output ready);
endinterface

interface srlt_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/srlt_front.sv
// ----------------------------------------------------------------------------
// srlt_front
// accepts items and turns each into a queued command for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlt_front (
    srlt_item_if.sink         items,
    input  srlt_pkg::q_stat_t q_stat,
    output logic              push,
    output srlt_pkg::cmd_t    cmd
);

    srlt_pkg::action_t act;

    assign items.ready = !q_stat.full;
    assign push        = items.valid && !q_stat.full;
    assign act         = srlt_pkg::action_t'(items.action);

    always_comb
    begin
        cmd.op                 = srlt_pkg::OP_SKIP;
        cmd.use_raw            = 1'b0;
        cmd.entry_index        = srlt_pkg::IDX_W'(items.entry_index);
        cmd.entry.virtual_base = items.load_virtual_base;
        cmd.entry.virtual_size = items.load_virtual_size;
        cmd.entry.raw_base     = items.load_raw_base;
        cmd.entry.raw_size     = items.load_raw_size;
        cmd.address            = items.query_address;
        // range end taken at 33 bits so it never wraps
        cmd.range_end          = {1'b0, items.query_address} + {1'b0, items.query_length};
        case (act)
            srlt_pkg::ACT_LOAD:
            begin
                // loads beyond the table are dropped but still answered
                if (int'(items.entry_index) < srlt_pkg::MAX_SECTIONS)
                    cmd.op = srlt_pkg::OP_WRITE;
                else
                    cmd.op = srlt_pkg::OP_SKIP;
            end
            srlt_pkg::ACT_FIND_VIRT:
            begin
                cmd.op = srlt_pkg::OP_SEARCH;
            end
            srlt_pkg::ACT_FIND_RAW:
            begin
                cmd.op      = srlt_pkg::OP_SEARCH;
                cmd.use_raw = 1'b1;
            end
            srlt_pkg::ACT_TRANSLATE:
            begin
                // point lookup, upper bound inclusive
                cmd.op        = srlt_pkg::OP_TRANSLATE;
                cmd.range_end = {1'b0, items.query_address};
            end
            default:
            begin
                cmd.op = srlt_pkg::OP_SKIP;
            end
        endcase
    end

endmodule

FILE: rtl/core/srlt_queue.sv
// ----------------------------------------------------------------------------
// srlt_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srlt_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output srlt_pkg::cmd_t     head_cmd,
    output srlt_pkg::q_stat_t  q_stat
);

    srlt_pkg::cmd_t                 slot_reg [srlt_pkg::QUEUE_DEPTH];
    logic [srlt_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [srlt_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [srlt_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign q_stat.full  = (cnt_reg == srlt_pkg::QCNT_W'(srlt_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == srlt_pkg::QPTR_W'(srlt_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + srlt_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == srlt_pkg::QPTR_W'(srlt_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + srlt_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + srlt_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - srlt_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: rtl/core/srlt_back.sv
// ----------------------------------------------------------------------------
// srlt_back
// section table, ordered first-match walk and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlt_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [srlt_pkg::COUNT_W-1:0]    section_count,
    input  srlt_pkg::q_stat_t               q_stat,
    input  srlt_pkg::cmd_t                  head_cmd,
    output logic                            pop,
    output srlt_pkg::bk_stat_t              bk_stat,
    srlt_result_if.source                   results
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    srlt_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [srlt_pkg::IDX_W-1:0]      walk_idx_reg, walk_idx_next;
    logic [srlt_pkg::NUM_W-1:0]      num_reg, num_next;
    logic                            found_reg, found_next;
    logic [srlt_pkg::IDX_W-1:0]      sect_reg, sect_next;
    logic [srlt_pkg::WORD_W-1:0]     hit_vb_reg, hit_vb_next;
    logic [srlt_pkg::WORD_W-1:0]     hit_rb_reg, hit_rb_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_found_reg, out_found_next;
    logic [srlt_pkg::ENTRY_IDX_W-1:0] out_sect_reg, out_sect_next;
    logic [srlt_pkg::WORD_W-1:0]     out_raw_reg, out_raw_next;

    srlt_pkg::entry_t                sect_mem [srlt_pkg::MAX_SECTIONS];
    srlt_pkg::entry_t                rd_entry_reg;

    logic                            out_free;
    logic [srlt_pkg::NUM_W-1:0]      num_sat;
    logic [srlt_pkg::WORD_W-1:0]     sel_base, sel_size;
    logic [srlt_pkg::WORD_W:0]       sel_top;
    logic                            hit, last;

    assign out_free = !out_valid_reg || results.ready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    // counts above the table size search the whole table
    assign num_sat = (int'(section_count) > srlt_pkg::MAX_SECTIONS)
                   ? srlt_pkg::NUM_W'(srlt_pkg::MAX_SECTIONS)
                   : srlt_pkg::NUM_W'(section_count);

    assign sel_base = cmd_reg.use_raw ? rd_entry_reg.raw_base : rd_entry_reg.virtual_base;
    assign sel_size = cmd_reg.use_raw ? rd_entry_reg.raw_size : rd_entry_reg.virtual_size;
    assign sel_top  = {1'b0, sel_base} + {1'b0, sel_size};
    assign hit      = (sel_base <= cmd_reg.address) && (cmd_reg.range_end <= sel_top);
    assign last     = (srlt_pkg::NUM_W'(walk_idx_reg) + srlt_pkg::NUM_W'(1) == num_reg);

    assign bk_stat.walking  = (state_reg == ST_WALK);
    assign bk_stat.walk_idx = walk_idx_reg;

    assign results.valid         = out_valid_reg;
    assign results.found         = out_found_reg;
    assign results.section_index = out_sect_reg;
    assign results.raw_address   = out_raw_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        walk_idx_next  = walk_idx_reg;
        num_next       = num_reg;
        found_next     = found_reg;
        sect_next      = sect_reg;
        hit_vb_next    = hit_vb_reg;
        hit_rb_next    = hit_rb_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_sect_next  = out_sect_reg;
        out_raw_next   = out_raw_reg;

        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next      = head_cmd;
                    walk_idx_next = '0;
                    num_next      = num_sat;
                    found_next    = 1'b0;
                    sect_next     = '0;
                    case (head_cmd.op)
                        srlt_pkg::OP_SEARCH, srlt_pkg::OP_TRANSLATE:
                        begin
                            if (num_sat == '0)
                                state_next = ST_FINISH;
                            else
                                state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // rd_entry_reg holds the entry at walk_idx_reg
                if (hit)
                begin
                    found_next  = 1'b1;
                    sect_next   = walk_idx_reg;
                    hit_vb_next = rd_entry_reg.virtual_base;
                    hit_rb_next = rd_entry_reg.raw_base;
                    state_next  = ST_FINISH;
                end
                else if (last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + srlt_pkg::IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_sect_next  = srlt_pkg::ENTRY_IDX_W'(sect_reg);
                    if (cmd_reg.op == srlt_pkg::OP_TRANSLATE)
                        out_raw_next = found_reg
                                     ? cmd_reg.address - hit_vb_reg + hit_rb_reg
                                     : srlt_pkg::ALL_ONES;
                    else
                        out_raw_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        walk_idx_reg  <= walk_idx_next;
        num_reg       <= num_next;
        found_reg     <= found_next;
        sect_reg      <= sect_next;
        hit_vb_reg    <= hit_vb_next;
        hit_rb_reg    <= hit_rb_next;
        out_found_reg <= out_found_next;
        out_sect_reg  <= out_sect_next;
        out_raw_reg   <= out_raw_next;
    end

    // section table, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (pop && (head_cmd.op == srlt_pkg::OP_WRITE))
            sect_mem[head_cmd.entry_index] <= head_cmd.entry;
        rd_entry_reg <= sect_mem[walk_idx_next];
    end

endmodule

FILE: rtl/core/section_range_lookup_translate_unit.sv
// ----------------------------------------------------------------------------
// section_range_lookup_translate_unit
// section table with first-match range search and address translation
//
// items: load writes one table entry; find by virtual or raw address returns
// the first of the first section_count entries that holds the whole range;
// translate maps a virtual address to a file offset. every item gives exactly
// one result on the results channel, in order.
// cfg: one write sets section_count; write it only while the unit is idle.
// flow: an item enters a two-deep command queue; the back end takes it when
// idle, walks the table one entry per cycle from entry 0 and stops at the
// first hit. the back end works on one item at a time and takes no new item
// until the result of the last one is in the output register.
// items keep being accepted while the queue has room, and a result waits in
// the output register while the receiver stalls; the back end holds the next
// result until it is taken. reset empties the queue and clears section_count;
// table entries are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "section_range_lookup_translate_unit_macros.svh"

module section_range_lookup_translate_unit (
    input  logic        clk,
    input  logic        rst_n,
    srlt_item_if.sink   items,
    srlt_cfg_if.sink    cfg,
    srlt_result_if.source results
);

    logic [srlt_pkg::COUNT_W-1:0] section_count_reg;
    srlt_pkg::q_stat_t            q_stat;
    srlt_pkg::bk_stat_t           bk_stat;
    srlt_pkg::cmd_t               push_cmd, head_cmd;
    logic                         push, pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            section_count_reg <= '0;
        else if (cfg.valid)
            section_count_reg <= cfg.data;
    end

    srlt_front u_front (
        .items   (items),
        .q_stat  (q_stat),
        .push    (push),
        .cmd     (push_cmd)
    );

    srlt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    srlt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .section_count (section_count_reg),
        .q_stat        (q_stat),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .bk_stat       (bk_stat),
        .results       (results)
    );

    // a miss always reports entry zero
    `SRLT_ASSERT_IMPL(a_miss_index_zero, clk, rst_n,
        results.valid && !results.found, results.section_index == '0)

    // the walk never goes past the searched entries
    `SRLT_ASSERT_IMPL(a_walk_in_range, clk, rst_n,
        bk_stat.walking,
        srlt_pkg::COUNT_W'(bk_stat.walk_idx) < section_count_reg)

    `SRLT_ASSERT_IMPL(a_queue_status, clk, rst_n, q_stat.full, !q_stat.empty)

    // an item pushed into an empty queue is held there
    `SRLT_ASSERT_NEXT(a_push_lands, clk, rst_n,
        items.valid && items.ready && q_stat.empty, !q_stat.empty)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// section lookup unit: table loads, first-match range finds in virtual and raw
// space and address translation, each result checked against an in-bench
// table model under bursty input and a stalling result sink
// ----------------------------------------------------------------------------

module testbench;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 68;

    typedef struct packed {
        srlt_pkg::action_t action;
        logic [3:0]  entry_index;
        logic [31:0] virtual_base;
        logic [31:0] virtual_size;
        logic [31:0] raw_base;
        logic [31:0] raw_size;
        logic [31:0] query_address;
        logic [31:0] query_length;
    } section_item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  section_index;
        logic [31:0] raw_address;
    } lookup_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_QUARTER,
        SINK_BURSTY
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    srlt_item_if   items_if ();
    srlt_result_if results_if ();
    srlt_cfg_if    cfg_if ();

    section_range_lookup_translate_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .cfg     (cfg_if),
        .results (results_if)
    );

    // table model and register shadow
    bit [31:0]   virt_base_tbl [srlt_pkg::MAX_SECTIONS];
    bit [31:0]   virt_size_tbl [srlt_pkg::MAX_SECTIONS];
    bit [31:0]   raw_base_tbl  [srlt_pkg::MAX_SECTIONS];
    bit [31:0]   raw_size_tbl  [srlt_pkg::MAX_SECTIONS];
    logic [4:0]  section_count_shadow = '0;

    lookup_t     lookups_due [$];

    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    int unsigned burst_left   = 0;
    int unsigned n_loads      = 0;
    int unsigned n_finds      = 0;
    int unsigned n_translates = 0;
    int unsigned n_hits       = 0;
    int unsigned n_cfg_writes = 0;

    sink_mode_t  sink_mode  = SINK_OPEN;
    int unsigned sink_left  = 0;
    int unsigned stall_left = 0;

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned active_sections();
        return (section_count_shadow > srlt_pkg::MAX_SECTIONS) ? srlt_pkg::MAX_SECTIONS
                                                               : section_count_shadow;
    endfunction

    // expected result of one item; loads update the table model
    function automatic lookup_t section_lookup(section_item_t it);
        lookup_t     r;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] q_end;
        r = '0;
        if (it.action == srlt_pkg::ACT_LOAD)
        begin
            if (it.entry_index < srlt_pkg::MAX_SECTIONS)
            begin
                virt_base_tbl[it.entry_index] = it.virtual_base;
                virt_size_tbl[it.entry_index] = it.virtual_size;
                raw_base_tbl[it.entry_index]  = it.raw_base;
                raw_size_tbl[it.entry_index]  = it.raw_size;
            end
            return r;
        end
        // 33-bit sums, no wrap; translate ignores the length
        q_end = {1'b0, it.query_address};
        if (it.action != srlt_pkg::ACT_TRANSLATE)
            q_end = q_end + {1'b0, it.query_length};
        for (int i = 0; i < active_sections() && !r.found; i++)
        begin
            if (it.action == srlt_pkg::ACT_FIND_RAW)
            begin
                lo = {1'b0, raw_base_tbl[i]};
                hi = lo + {1'b0, raw_size_tbl[i]};
            end
            else
            begin
                lo = {1'b0, virt_base_tbl[i]};
                hi = lo + {1'b0, virt_size_tbl[i]};
            end
            if (lo <= {1'b0, it.query_address} && q_end <= hi)
            begin
                r.found         = 1'b1;
                r.section_index = 4'(i);
            end
        end
        if (it.action == srlt_pkg::ACT_TRANSLATE)
        begin
            if (r.found)
                r.raw_address = it.query_address - virt_base_tbl[r.section_index]
                                + raw_base_tbl[r.section_index];
            else
                r.raw_address = srlt_pkg::ALL_ONES;
        end
        return r;
    endfunction

    function automatic section_item_t make_load(logic [3:0] idx, logic [31:0] vb, vs, rb, rs);
        section_item_t it;
        it.action        = srlt_pkg::ACT_LOAD;
        it.entry_index   = idx;
        it.virtual_base  = vb;
        it.virtual_size  = vs;
        it.raw_base      = rb;
        it.raw_size      = rs;
        it.query_address = $urandom;
        it.query_length  = $urandom;
        return it;
    endfunction

    function automatic section_item_t make_query(srlt_pkg::action_t act,
                                                 logic [31:0] addr, len);
        section_item_t it;
        it.action        = act;
        it.entry_index   = 4'($urandom_range(0, 15));
        it.virtual_base  = $urandom;
        it.virtual_size  = $urandom;
        it.raw_base      = $urandom;
        it.raw_size      = $urandom;
        it.query_address = addr;
        it.query_length  = len;
        return it;
    endfunction

    function automatic section_item_t random_load(logic [3:0] idx);
        section_item_t it;
        logic [3:0]    peer;
        it   = make_load(idx, $urandom, $urandom, $urandom, $urandom);
        peer = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 4))
            0:
            begin
                // lands on top of another entry so the first match decides
                it.virtual_base = virt_base_tbl[peer] + $urandom_range(0, 64);
                it.raw_base     = raw_base_tbl[peer] + $urandom_range(0, 64);
                it.virtual_size = $urandom_range(0, 'h1FFF);
                it.raw_size     = $urandom_range(0, 'h1FFF);
            end
            1:
            begin
                it.virtual_size = $urandom_range(0, 'hFFF);
                it.raw_size     = $urandom_range(0, 'hFFF);
            end
            2:
            begin
                // ends past the 32-bit space
                it.virtual_base = 32'hFFFF_F000 | $urandom_range(0, 'hFFF);
                it.raw_base     = 32'hFFFF_F000 | $urandom_range(0, 'hFFF);
                it.virtual_size = $urandom_range(0, 'h3FFF);
                it.raw_size     = $urandom_range(0, 'h3FFF);
            end
            3:
            begin
                it.virtual_size = $urandom_range(0, 1) ? srlt_pkg::ALL_ONES : '0;
                it.raw_size     = $urandom_range(0, 1) ? srlt_pkg::ALL_ONES : '0;
            end
            default: ;
        endcase
        return it;
    endfunction

    // mostly queries aimed at the edges of a live entry
    function automatic section_item_t random_item();
        srlt_pkg::action_t act;
        int unsigned pick;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] span;
        logic [31:0] addr;
        logic [31:0] len;
        if ($urandom_range(0, 3) == 0)
            return random_load(4'($urandom_range(0, 15)));
        act = srlt_pkg::action_t'($urandom_range(1, 3));
        if ($urandom_range(0, 4) == 0)
            return make_query(act, $urandom, $urandom);
        pick = (active_sections() == 0) ? $urandom_range(0, 15)
                                        : $urandom_range(0, active_sections() - 1);
        if (act == srlt_pkg::ACT_FIND_RAW)
        begin
            lo = {1'b0, raw_base_tbl[pick]};
            hi = lo + {1'b0, raw_size_tbl[pick]};
        end
        else
        begin
            lo = {1'b0, virt_base_tbl[pick]};
            hi = lo + {1'b0, virt_size_tbl[pick]};
        end
        span = hi - lo;
        case ($urandom_range(0, 3))
            0:       addr = lo[31:0];
            1:       addr = hi[31:0];
            2:       addr = lo[31:0] + $urandom_range(span[31:0], 0);
            default: addr = lo[31:0] + $urandom_range(0, 3);
        endcase
        span = hi - {1'b0, addr};
        case ($urandom_range(0, 4))
            0:       len = '0;
            1:       len = span[31:0];
            2:       len = span[31:0] + 1;
            3:       len = $urandom_range(0, 255);
            default: len = $urandom;
        endcase
        return make_query(act, addr, len);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // sender side: bursts of random length with random gaps in between
    task automatic send_item(section_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                items_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        items_if.valid             = 1'b1;
        items_if.action            = it.action;
        items_if.entry_index       = it.entry_index;
        items_if.load_virtual_base = it.virtual_base;
        items_if.load_virtual_size = it.virtual_size;
        items_if.load_raw_base     = it.raw_base;
        items_if.load_raw_size     = it.raw_size;
        items_if.query_address     = it.query_address;
        items_if.query_length      = it.query_length;
        do @(posedge clk); while (!items_if.ready);
        lookups_due.insert(lookups_due.size(), section_lookup(it));
        case (it.action)
            srlt_pkg::ACT_LOAD:      n_loads++;
            srlt_pkg::ACT_TRANSLATE: n_translates++;
            default:                 n_finds++;
        endcase
        @(negedge clk);
    endtask

    // hold the input off until every result is back and the walk has settled
    task automatic wait_until_idle();
        items_if.valid = 1'b0;
        while (lookups_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_section_count(logic [4:0] value);
        wait_until_idle();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge clk); while (!cfg_if.ready);
        section_count_shadow = value;
        n_cfg_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // count of zero after reset: nothing is searched
    task automatic test_empty_table();
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, '0, '0));
        send_item(make_query(srlt_pkg::ACT_FIND_RAW, $urandom, $urandom));
        send_item(make_query(srlt_pkg::ACT_TRANSLATE, '0, srlt_pkg::ALL_ONES));
    endtask

    task automatic test_boundaries();
        send_item(make_load(0, '0, '0, srlt_pkg::ALL_ONES, srlt_pkg::ALL_ONES));
        send_item(make_load(1, srlt_pkg::ALL_ONES, srlt_pkg::ALL_ONES,
                            32'h0000_1000, 32'h0000_0200));
        send_item(make_load(2, 32'h0040_0000, 32'h0000_1000, 32'h0000_0400, 32'h0000_0800));
        send_item(make_load(3, 32'h0040_0000, 32'h0001_0000, 32'hFFFF_F000, 32'h0000_1000));
        write_section_count(5'd4);
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, '0, '0));
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, '0, 32'd1));
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, 32'h0040_0000, 32'h0000_1000));
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, 32'h0040_0000, 32'h0000_1001));
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, srlt_pkg::ALL_ONES, srlt_pkg::ALL_ONES));
        send_item(make_query(srlt_pkg::ACT_FIND_RAW, srlt_pkg::ALL_ONES, srlt_pkg::ALL_ONES));
        send_item(make_query(srlt_pkg::ACT_FIND_RAW, 32'h0000_1000, 32'h0000_0200));
        send_item(make_query(srlt_pkg::ACT_FIND_RAW, '0, '0));
        // hit whose offset comes out as all ones
        send_item(make_query(srlt_pkg::ACT_TRANSLATE, '0, '0));
        // inclusive upper bound
        send_item(make_query(srlt_pkg::ACT_TRANSLATE, 32'h0040_1000, '0));
        // length ignored, offset wraps round 2^32
        send_item(make_query(srlt_pkg::ACT_TRANSLATE, 32'h0040_1001, srlt_pkg::ALL_ONES));
        send_item(make_query(srlt_pkg::ACT_TRANSLATE, 32'h0000_0010, '0));
        write_section_count(5'd1);
        send_item(make_query(srlt_pkg::ACT_FIND_VIRT, 32'h0040_0000, 32'h0000_1000));
    endtask

    task automatic test_random_traffic();
        logic [4:0] settings [8];
        settings = '{5'd16, 5'd31, 5'd17, 5'd0, 5'd1, 5'd8, 5'd15, 5'd0};
        settings[7] = 5'($urandom_range(0, 31));
        // every entry written before any count above four is set
        for (int i = 4; i < srlt_pkg::MAX_SECTIONS; i++)
            send_item(random_load(4'(i)));
        for (int p = 0; p < 8; p++)
        begin
            write_section_count(settings[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_item(random_item());
                if (p == 2 && k == PHASE_ITEMS / 2)
                    wait_until_idle();
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (lookups_due.size() == 0)
                report_mismatch($sformatf("result with none due: found %0b section %0d raw %h",
                                          results_if.found, results_if.section_index,
                                          results_if.raw_address));
            else
            begin
                want = lookups_due.pop_front();
                if (results_if.found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              results_if.found, want.found));
                if (results_if.section_index !== want.section_index)
                    report_mismatch($sformatf("section_index %0d, expected %0d",
                                              results_if.section_index, want.section_index));
                if (results_if.raw_address !== want.raw_address)
                    report_mismatch($sformatf("raw_address %h, expected %h",
                                              results_if.raw_address, want.raw_address));
                if (want.found)
                    n_hits++;
            end
        end
    end

    // receiver side: open, coin toss, one in four, or mostly open with long stalls
    always @(negedge clk)
    begin : sink_pattern
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 200);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:    results_if.ready = 1'b1;
            SINK_COIN:    results_if.ready = 1'($urandom_range(0, 1));
            SINK_QUARTER: results_if.ready = (sink_left % 4 == 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    results_if.ready = 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left       = $urandom_range(4, 20);
                    results_if.ready = 1'b0;
                end
                else
                    results_if.ready = 1'b1;
            end
        endcase
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, lookups_due.size());
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        rst_n                      = 1'b0;
        items_if.valid             = 1'b0;
        items_if.action            = srlt_pkg::ACT_LOAD;
        items_if.entry_index       = '0;
        items_if.load_virtual_base = '0;
        items_if.load_virtual_size = '0;
        items_if.load_raw_base     = '0;
        items_if.load_raw_size     = '0;
        items_if.query_address     = '0;
        items_if.query_length      = '0;
        cfg_if.valid               = 1'b0;
        cfg_if.data                = '0;
        results_if.ready           = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_boundaries();
        test_random_traffic();
        wait_until_idle();

        if (lookups_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", lookups_due.size()));
        $display("run covered %0d loads, %0d finds and %0d translates, %0d of them hits",
                 n_loads, n_finds, n_translates, n_hits);
        $display("section count written %0d times, %0d mismatches, %0d cycles",
                 n_cfg_writes, errors, cycles);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
